/* src/connection_slot_allocator_macros.svh */
// Assertion macros shared by the connection slot allocator RTL.
`ifndef CONNECTION_SLOT_ALLOCATOR_MACROS_SVH
`define CONNECTION_SLOT_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define CSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CSA_ASSERT(lbl, prop, msg)
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/csa_pkg.sv */
// Types, codes and constants of the connection slot allocator.
`default_nettype none
package csa_pkg;
  localparam int SLOT_COUNT_DEF = 64;

  localparam logic [6:0] NIL_LINK = 7'd127;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TOUCH = 2'd2;
  localparam logic [1:0] OP_SCAN  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  handle_index;
    logic [31:0] handle_tag;
    logic        listener;
    logic [31:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_index;
    logic [31:0] out_tag;
    logic [6:0]  used_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  next;
    logic [6:0]  prev;
    logic [31:0] tag;
    logic [31:0] stamp;
  } slot_word_t;

  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    slot_word_t wdata;
    logic       re;
    logic [5:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [5:0] wdata;
    logic       re;
    logic [5:0] raddr;
  } fq_req_t;
endpackage
`default_nettype wire

/* src/csa_if.sv */
// Request and result channel interfaces of the connection slot allocator.
`default_nettype none
interface csa_in_if;
  logic              valid;
  logic              ready;
  csa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csa_out_if;
  logic               valid;
  logic               ready;
  csa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/csa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csa_ram #(
  parameter int W = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/csa_core.sv */
// Sequencer of the slot allocator: free FIFO, used list and slot table updates.
`default_nettype none
`include "connection_slot_allocator_macros.svh"
module csa_core #(
  parameter int SLOT_COUNT = csa_pkg::SLOT_COUNT_DEF,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire csa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output csa_pkg::out_item_t      out_data,
  output csa_pkg::slot_req_t      slot_req,
  input  wire csa_pkg::slot_word_t slot_rdata,
  output csa_pkg::fq_req_t        fq_req,
  input  wire logic [5:0]         fq_rdata
);
  import csa_pkg::*;

  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);
  localparam logic [6:0] SLOTS7 = 7'(SLOT_COUNT);

  typedef enum logic [11:0] {
    S_INIT = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_AL1  = 12'b000000000100,
    S_AL2  = 12'b000000001000,
    S_AL3  = 12'b000000010000,
    S_CK1  = 12'b000000100000,
    S_CK2  = 12'b000001000000,
    S_FPW  = 12'b000010000000,
    S_FNW  = 12'b000100000000,
    S_SCR  = 12'b001000000000,
    S_SCE  = 12'b010000000000,
    S_RSP  = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   init_r, init_nxt;
  logic [AW-1:0]   fhead_r, fhead_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   busy_cnt_r, busy_cnt_nxt;
  logic [SLOT_COUNT-1:0] busy_r, busy_nxt;
  logic [6:0]      head_r, head_nxt;
  logic [6:0]      tail_r, tail_nxt;
  logic [31:0]     tcnt_r, tcnt_nxt;
  in_item_t        req_r, req_nxt;
  logic [6:0]      p_r, p_nxt;
  logic [6:0]      n_r, n_nxt;
  logic [6:0]      cur_r, cur_nxt;
  logic [CW-1:0]   guard_r, guard_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [5:0]      pend_idx_r, pend_idx_nxt;
  logic [31:0]     pend_tag_r, pend_tag_nxt;
  logic [2:0]      rsp_st_r, rsp_st_nxt;
  logic [5:0]      rsp_idx_r, rsp_idx_nxt;
  logic [31:0]     rsp_tag_r, rsp_tag_nxt;
  logic            out_v_r, out_v_nxt;
  out_item_t       out_d_r, out_d_nxt;

  logic            out_free;
  logic [CW:0]     tail_sum;
  logic [AW-1:0]   fq_tail;
  logic [31:0]     tcnt1;
  logic [AW-1:0]   req_idx;
  logic            qual;

  assign out_free = !out_v_r || out_ready;
  assign tail_sum = {1'b0, CW'(fhead_r)} + {1'b0, fill_r};
  assign fq_tail  = (tail_sum >= {1'b0, SLOTS}) ? AW'(tail_sum - {1'b0, SLOTS})
                                                : AW'(tail_sum);
  assign tcnt1    = (tcnt_r == 32'd0) ? 32'd1 : tcnt_r;
  assign req_idx  = req_r.handle_index[AW-1:0];
  assign qual     = (slot_rdata.tag != 32'd0) && (slot_rdata.stamp <= req_r.time_value);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    state_nxt    = state_r;
    init_nxt     = init_r;
    fhead_nxt    = fhead_r;
    fill_nxt     = fill_r;
    busy_cnt_nxt = busy_cnt_r;
    busy_nxt     = busy_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    tcnt_nxt     = tcnt_r;
    req_nxt      = req_r;
    p_nxt        = p_r;
    n_nxt        = n_r;
    cur_nxt      = cur_r;
    guard_nxt    = guard_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_tag_nxt = pend_tag_r;
    rsp_st_nxt   = rsp_st_r;
    rsp_idx_nxt  = rsp_idx_r;
    rsp_tag_nxt  = rsp_tag_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_d_nxt    = out_d_r;
    slot_req     = '0;
    fq_req       = '0;

    unique case (state_r)
      S_INIT: begin
        fq_req.we    = 1'b1;
        fq_req.waddr = 6'(init_r);
        fq_req.wdata = 6'(init_r);
        init_nxt     = init_r + AW'(1);
        if (init_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          rsp_st_nxt  = ST_OK;
          rsp_idx_nxt = 6'd0;
          rsp_tag_nxt = 32'd0;
          unique case (in_data.opcode)
            OP_ALLOC: begin
              if (fill_r == '0) begin
                rsp_st_nxt = ST_FULL;
                state_nxt  = S_RSP;
              end else begin
                state_nxt = S_AL1;
              end
            end
            OP_FREE, OP_TOUCH: state_nxt = S_CK1;
            default: begin
              cur_nxt    = head_r;
              guard_nxt  = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCR;
            end
          endcase
        end
      end
      S_AL1: begin
        fq_req.re    = 1'b1;
        fq_req.raddr = 6'(fhead_r);
        fhead_nxt    = (fhead_r == LAST_IDX) ? '0 : fhead_r + AW'(1);
        fill_nxt     = fill_r - CW'(1);
        busy_cnt_nxt = busy_cnt_r + CW'(1);
        if (req_r.listener) begin
          rsp_tag_nxt = 32'd0;
          tcnt_nxt    = tcnt1;
        end else begin
          rsp_tag_nxt = tcnt1;
          tcnt_nxt    = tcnt1 + 32'd1;
        end
        state_nxt = S_AL2;
      end
      S_AL2: begin
        busy_nxt[fq_rdata[AW-1:0]] = 1'b1;
        rsp_idx_nxt          = fq_rdata;
        slot_req.we          = 1'b1;
        slot_req.waddr       = fq_rdata;
        slot_req.wdata.next  = NIL_LINK;
        slot_req.wdata.prev  = tail_r;
        slot_req.wdata.tag   = rsp_tag_r;
        slot_req.wdata.stamp = req_r.time_value;
        if (tail_r != NIL_LINK) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = tail_r[5:0];
          state_nxt      = S_AL3;
        end else begin
          head_nxt  = {1'b0, fq_rdata};
          tail_nxt  = {1'b0, fq_rdata};
          state_nxt = S_RSP;
        end
      end
      S_AL3: begin
        slot_req.we         = 1'b1;
        slot_req.waddr      = tail_r[5:0];
        slot_req.wdata      = slot_rdata;
        slot_req.wdata.next = {1'b0, rsp_idx_r};
        tail_nxt            = {1'b0, rsp_idx_r};
        state_nxt           = S_RSP;
      end
      S_CK1: begin
        if (({1'b0, req_r.handle_index} >= SLOTS7) || !busy_r[req_idx]) begin
          rsp_st_nxt = ST_NOTFOUND;
          state_nxt  = S_RSP;
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = req_r.handle_index;
          state_nxt      = S_CK2;
        end
      end
      S_CK2: begin
        if (slot_rdata.tag != req_r.handle_tag) begin
          rsp_st_nxt = ST_NOTFOUND;
          state_nxt  = S_RSP;
        end else if (req_r.opcode == OP_TOUCH) begin
          slot_req.we          = 1'b1;
          slot_req.waddr       = req_r.handle_index;
          slot_req.wdata       = slot_rdata;
          slot_req.wdata.stamp = req_r.time_value;
          state_nxt            = S_RSP;
        end else begin
          // unlink, clear the slot, push the index onto the free tail
          p_nxt                = slot_rdata.prev;
          n_nxt                = slot_rdata.next;
          slot_req.we          = 1'b1;
          slot_req.waddr       = req_r.handle_index;
          slot_req.wdata.next  = NIL_LINK;
          slot_req.wdata.prev  = NIL_LINK;
          slot_req.wdata.tag   = 32'd0;
          slot_req.wdata.stamp = slot_rdata.stamp;
          busy_nxt[req_idx]    = 1'b0;
          fq_req.we            = 1'b1;
          fq_req.waddr         = 6'(fq_tail);
          fq_req.wdata         = req_r.handle_index;
          fill_nxt             = fill_r + CW'(1);
          busy_cnt_nxt         = busy_cnt_r - CW'(1);
          if (slot_rdata.prev == NIL_LINK) head_nxt = slot_rdata.next;
          if (slot_rdata.next == NIL_LINK) tail_nxt = slot_rdata.prev;
          if (slot_rdata.prev != NIL_LINK) begin
            slot_req.re    = 1'b1;
            slot_req.raddr = slot_rdata.prev[5:0];
            state_nxt      = S_FPW;
          end else if (slot_rdata.next != NIL_LINK) begin
            slot_req.re    = 1'b1;
            slot_req.raddr = slot_rdata.next[5:0];
            state_nxt      = S_FNW;
          end else begin
            state_nxt = S_RSP;
          end
        end
      end
      S_FPW: begin
        slot_req.we         = 1'b1;
        slot_req.waddr      = p_r[5:0];
        slot_req.wdata      = slot_rdata;
        slot_req.wdata.next = n_r;
        if (n_r != NIL_LINK) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = n_r[5:0];
          state_nxt      = S_FNW;
        end else begin
          state_nxt = S_RSP;
        end
      end
      S_FNW: begin
        slot_req.we         = 1'b1;
        slot_req.waddr      = n_r[5:0];
        slot_req.wdata      = slot_rdata;
        slot_req.wdata.prev = p_r;
        state_nxt           = S_RSP;
      end
      S_SCR: begin
        if ((cur_r != NIL_LINK) && (guard_r < SLOTS)) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = cur_r[5:0];
          state_nxt      = S_SCE;
        end else begin
          if (pend_v_r) begin
            rsp_st_nxt  = ST_EXPIRED;
            rsp_idx_nxt = pend_idx_r;
            rsp_tag_nxt = pend_tag_r;
          end else begin
            rsp_st_nxt = ST_NONE;
          end
          state_nxt = S_RSP;
        end
      end
      S_SCE: begin
        // a new hit releases the held one, so last lands on the final hit
        if (!(qual && pend_v_r && !out_free)) begin
          if (qual && pend_v_r) begin
            out_v_nxt = 1'b1;
            out_d_nxt = '{status: ST_EXPIRED, out_index: pend_idx_r,
                          out_tag: pend_tag_r, used_count: 7'(busy_cnt_r), last: 1'b0};
          end
          if (qual) begin
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = cur_r[5:0];
            pend_tag_nxt = slot_rdata.tag;
          end
          cur_nxt   = slot_rdata.next;
          guard_nxt = guard_r + CW'(1);
          state_nxt = S_SCR;
        end
      end
      S_RSP: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = '{status: rsp_st_r, out_index: rsp_idx_r, out_tag: rsp_tag_r,
                        used_count: 7'(busy_cnt_r), last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_r     <= '0;
      fhead_r    <= '0;
      fill_r     <= SLOTS;
      busy_cnt_r <= '0;
      busy_r     <= '0;
      head_r     <= NIL_LINK;
      tail_r     <= NIL_LINK;
      tcnt_r     <= 32'd0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      fhead_r    <= fhead_nxt;
      fill_r     <= fill_nxt;
      busy_cnt_r <= busy_cnt_nxt;
      busy_r     <= busy_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      tcnt_r     <= tcnt_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    cur_r      <= cur_nxt;
    guard_r    <= guard_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    rsp_st_r   <= rsp_st_nxt;
    rsp_idx_r  <= rsp_idx_nxt;
    rsp_tag_r  <= rsp_tag_nxt;
    out_d_r    <= out_d_nxt;
  end

  // free and busy slots always account for the whole table
  `CSA_ASSERT(a_slot_total, ({1'b0, fill_r} + {1'b0, busy_cnt_r}) == {1'b0, SLOTS}, "slot count lost")
  // one request at a time
  `CSA_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request taken while busy")
  // list is empty exactly when no slot is busy
  `CSA_ASSERT(a_list_empty, (state_r == S_IDLE) |-> ((head_r == NIL_LINK) == (busy_cnt_r == '0)), "used list out of step")
endmodule
`default_nettype wire

/* src/connection_slot_allocator.sv */
// Top level of the connection slot allocator: sequencer and its two RAMs.
//
//  channel   dir  payload                                            accepted when
//  in_chan   in   opcode, handle_index, handle_tag, listener, time   valid && ready
//  out_chan  out  status, out_index, out_tag, used_count, last       valid && ready
//
// One request at a time. Allocate pops an index from the free FIFO and writes
// the new slot, then links the old tail to it when the used list is not empty;
// a full table is answered with no RAM access. Touch and free read the slot,
// and free relinks its neighbors; a handle rejected on its index or busy
// bit is answered with no slot table read. Each walks the slot table RAM
// through its single read and single write port. Expire scan makes one slot
// table read per slot on the used list, visiting at most SLOT_COUNT slots.
// After reset a clearing pass loads the free FIFO with
// indices in order; in_chan.ready stays low during it.
// A result waits in the output register; a stalled out_chan holds the
// sequencer at its next result.
`default_nettype none
module connection_slot_allocator #(
  parameter int SLOT_COUNT = csa_pkg::SLOT_COUNT_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  csa_in_if.sink    in_chan,
  csa_out_if.source out_chan
);
  import csa_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  slot_req_t  slot_req;
  slot_word_t slot_rdata;
  fq_req_t    fq_req;
  logic [5:0] fq_rdata;

  csa_core #(.SLOT_COUNT(SLOT_COUNT)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_data    (in_chan.data),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_data   (out_chan.data),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata),
    .fq_req     (fq_req),
    .fq_rdata   (fq_rdata)
  );

  // slot table: links, tag and access time per slot
  csa_ram #(.W($bits(slot_word_t)), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_req.we),
    .waddr (slot_req.waddr[AW-1:0]),
    .wdata (slot_req.wdata),
    .re    (slot_req.re),
    .raddr (slot_req.raddr[AW-1:0]),
    .rdata (slot_rdata)
  );

  // free FIFO of slot indices
  csa_ram #(.W(6), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk   (clk),
    .we    (fq_req.we),
    .waddr (fq_req.waddr[AW-1:0]),
    .wdata (fq_req.wdata),
    .re    (fq_req.re),
    .raddr (fq_req.raddr[AW-1:0]),
    .rdata (fq_rdata)
  );
endmodule
`default_nettype wire

/* tb/sv/tb_connection_slot_allocator.sv */
// Self-checking testbench for the connection slot allocator.
`timescale 1ns / 100ps
`default_nettype none
module tb_connection_slot_allocator;
  import csa_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] tag;
  } handle_t;

  // A queued request; the flags say how the driver completes it at send time.
  typedef struct {
    in_item_t req;
    bit       from_live;   // take the handle of a busy slot
    bit       from_stale;  // take a handle that was already freed
    bit       drain;       // hold until every expected result has come
  } pending_t;

  logic clk;
  logic rst_n;

  csa_in_if  in_chan ();
  csa_out_if out_chan ();

  connection_slot_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the allocator: free FIFO, busy list, per-slot fields.
  logic [5:0]  fifo_slots [SLOTS];
  logic [5:0]  fifo_head;
  logic [6:0]  fifo_fill;
  logic [6:0]  link_next [SLOTS];
  logic [6:0]  link_prev [SLOTS];
  logic [6:0]  list_head;
  logic [6:0]  list_tail;
  logic [31:0] tag_of [SLOTS];
  logic [31:0] stamp_of [SLOTS];
  bit          busy_of [SLOTS];
  logic [31:0] next_tag;
  logic [6:0]  busy_total;

  out_item_t outcome_q[$];
  pending_t  request_q[$];
  handle_t   live_q[$];
  handle_t   stale_q[$];

  int  errors;
  int  accepted_reqs;
  int  stall_cycles;
  bit  took;
  int  hold_left;
  bit  hold_done;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void reset_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      fifo_slots[i] = 6'(i);
      link_next[i] = NIL_LINK;
      link_prev[i] = NIL_LINK;
      tag_of[i] = '0;
      stamp_of[i] = '0;
      busy_of[i] = 1'b0;
    end
    fifo_head = '0;
    fifo_fill = 7'(SLOTS);
    list_head = NIL_LINK;
    list_tail = NIL_LINK;
    next_tag = '0;
    busy_total = '0;
  endfunction

  function automatic void expect_result(logic [2:0] st, logic [5:0] idx, logic [31:0] tag,
                                        bit lst);
    out_item_t r;
    r.status = st;
    r.out_index = idx;
    r.out_tag = tag;
    r.used_count = busy_total;
    r.last = lst;
    outcome_q.push_back(r);
  endfunction

  function automatic bit handle_valid(logic [5:0] idx, logic [31:0] tag);
    return busy_of[idx] && tag_of[idx] == tag;
  endfunction

  // Works out the results of one accepted request and updates the shadow.
  function automatic void predict_outcome(in_item_t r);
    logic [5:0] s;
    logic [31:0] t;
    logic [6:0] p, n, cur;
    int found;
    case (r.opcode)
      OP_ALLOC: begin
        if (fifo_fill == 0) begin
          expect_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          s = fifo_slots[fifo_head];
          fifo_head = fifo_head + 6'd1;
          fifo_fill--;
          if (next_tag == 0) next_tag = 32'd1;
          if (r.listener) begin
            t = '0;
          end else begin
            t = next_tag;
            next_tag = next_tag + 32'd1;
          end
          tag_of[s] = t;
          stamp_of[s] = r.time_value;
          busy_of[s] = 1'b1;
          busy_total++;
          link_next[s] = NIL_LINK;
          link_prev[s] = list_tail;
          if (list_tail != NIL_LINK) link_next[list_tail[5:0]] = {1'b0, s};
          else list_head = {1'b0, s};
          list_tail = {1'b0, s};
          live_q.push_back('{idx: s, tag: t});
          expect_result(ST_OK, s, t, 1'b1);
        end
      end
      OP_FREE: begin
        if (!handle_valid(r.handle_index, r.handle_tag)) begin
          expect_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          s = r.handle_index;
          p = link_prev[s];
          n = link_next[s];
          if (p != NIL_LINK) link_next[p[5:0]] = n;
          else list_head = n;
          if (n != NIL_LINK) link_prev[n[5:0]] = p;
          else list_tail = p;
          link_next[s] = NIL_LINK;
          link_prev[s] = NIL_LINK;
          busy_of[s] = 1'b0;
          tag_of[s] = '0;
          fifo_slots[6'(fifo_head + fifo_fill[5:0])] = s;
          fifo_fill++;
          busy_total--;
          for (int i = 0; i < live_q.size(); i++)
            if (live_q[i].idx == s) begin
              stale_q.push_back(live_q[i]);
              live_q.delete(i);
              break;
            end
          expect_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_TOUCH: begin
        if (!handle_valid(r.handle_index, r.handle_tag)) begin
          expect_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          stamp_of[r.handle_index] = r.time_value;
          expect_result(ST_OK, '0, '0, 1'b1);
        end
      end
      default: begin
        // Expire scan: walk in allocation order, listeners carry tag zero.
        found = 0;
        cur = list_head;
        for (int g = 0; g < SLOTS && cur != NIL_LINK; g++) begin
          if (tag_of[cur[5:0]] != 0 && stamp_of[cur[5:0]] <= r.time_value) begin
            expect_result(ST_EXPIRED, cur[5:0], tag_of[cur[5:0]], 1'b0);
            found++;
          end
          cur = link_next[cur[5:0]];
        end
        if (found == 0) expect_result(ST_NONE, '0, '0, 1'b1);
        else outcome_q[outcome_q.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // Monitor, predictor hookup and watchdog, all on the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      took <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (outcome_q.size() == 0) begin
          report("result with no request pending", 32'(out_chan.data.status), '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_chan.data.status !== want.status)
            report("status", 32'(out_chan.data.status), 32'(want.status));
          if (out_chan.data.out_index !== want.out_index)
            report("out_index", 32'(out_chan.data.out_index), 32'(want.out_index));
          if (out_chan.data.out_tag !== want.out_tag)
            report("out_tag", out_chan.data.out_tag, want.out_tag);
          if (out_chan.data.used_count !== want.used_count)
            report("used_count", 32'(out_chan.data.used_count), 32'(want.used_count));
          if (out_chan.data.last !== want.last)
            report("last", 32'(out_chan.data.last), 32'(want.last));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        predict_outcome(in_chan.data);
        accepted_reqs++;
      end
      took <= in_chan.valid && in_chan.ready;
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // No random idling in the middle stretch of the run.
  function automatic bit idle_now();
    if (accepted_reqs >= 150 && accepted_reqs < 230) return 1'b0;
    return $urandom_range(99) < 15;
  endfunction

  // Request driver: a request stays up unchanged until it is taken.
  always @(negedge clk) begin
    pending_t nxt;
    in_item_t r;
    handle_t h;
    if (rst_n && (!in_chan.valid || took)) begin
      if (request_q.size() == 0 || (request_q[0].drain && outcome_q.size() != 0) ||
          idle_now()) begin
        in_chan.valid <= 1'b0;
      end else begin
        nxt = request_q.pop_front();
        r = nxt.req;
        if (nxt.from_live && live_q.size() != 0) begin
          h = live_q[$urandom_range(live_q.size() - 1)];
          r.handle_index = h.idx;
          r.handle_tag = h.tag;
          // now and then a wrong tag on a busy slot
          if ($urandom_range(9) == 0) r.handle_tag[$urandom_range(31)] ^= 1'b1;
        end else if (nxt.from_stale && stale_q.size() != 0) begin
          h = stale_q[$urandom_range(stale_q.size() - 1)];
          r.handle_index = h.idx;
          r.handle_tag = h.tag;
        end
        in_chan.valid <= 1'b1;
        in_chan.data <= r;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off while requests keep coming.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= 60) begin
        out_chan.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_chan.ready <= !idle_now();
      end
    end
  end

  function automatic void queue_request(logic [1:0] op, logic [5:0] idx, logic [31:0] tag,
                                        bit lis, logic [31:0] tv, bit live = 0,
                                        bit stale = 0, bit drain = 0);
    pending_t p;
    p.req.opcode = op;
    p.req.handle_index = idx;
    p.req.handle_tag = tag;
    p.req.listener = lis;
    p.req.time_value = tv;
    p.from_live = live;
    p.from_stale = stale;
    p.drain = drain;
    request_q.push_back(p);
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return $urandom;
      default: return $urandom_range(1000);
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    int roll, phase;
    errors = 0;
    accepted_reqs = 0;
    hold_left = 0;
    hold_done = 1'b0;
    took = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    reset_shadow();

    // Directed: empty scan, unused slot, listener, tag checks, double free.
    queue_request(OP_SCAN, '0, '0, 1'b0, '1);
    queue_request(OP_FREE, 6'd5, '0, 1'b0, '0);
    queue_request(OP_ALLOC, '0, '0, 1'b0, 32'd100);
    queue_request(OP_ALLOC, '1, '1, 1'b1, '0);
    queue_request(OP_ALLOC, '0, '0, 1'b0, '1);
    queue_request(OP_TOUCH, 6'd0, 32'd1, 1'b0, 32'd50);
    queue_request(OP_TOUCH, 6'd0, 32'd2, 1'b0, 32'd60);
    queue_request(OP_TOUCH, 6'd1, '0, 1'b0, 32'd7);
    queue_request(OP_SCAN, '0, '0, 1'b0, '0);
    queue_request(OP_SCAN, '0, '0, 1'b0, 32'd50);
    queue_request(OP_SCAN, '0, '0, 1'b0, '1);
    queue_request(OP_FREE, 6'd0, 32'd1, 1'b0, '0);
    queue_request(OP_FREE, 6'd0, 32'd1, 1'b0, '0);
    queue_request(OP_FREE, 6'd63, '1, 1'b0, '1);
    queue_request(OP_TOUCH, 6'd1, '0, 1'b1, '1);
    queue_request(OP_ALLOC, '0, '0, 1'b0, 32'd3);

    // Random: phases lean to filling, mixing, then draining the table.
    for (int i = 0; i < 385; i++) begin
      phase = (i / 80) % 3;
      roll = $urandom_range(99);
      if (phase == 0) op = roll < 85 ? OP_ALLOC : (roll < 92 ? OP_TOUCH : OP_SCAN);
      else if (phase == 1) op = 2'($urandom_range(3));
      else op = roll < 15 ? OP_ALLOC : (roll < 75 ? OP_FREE : (roll < 88 ? OP_TOUCH : OP_SCAN));
      roll = $urandom_range(99);
      queue_request(op, 6'($urandom), $urandom, $urandom_range(7) == 0, pick_time(),
                    roll < 85, roll >= 85 && roll < 92, i == 200 || i == 330);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_chan.valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
